FILE: rtl/rfb_pkg.sv
// ----------------------------------------------------------------------------
// rfb_pkg
// Shared types, codes and helpers of the ring FIFO with batch operations.
// ----------------------------------------------------------------------------
package rfb_pkg;

  localparam int PTR_W = 6;
  localparam int CNT_W = 7;
  localparam int ELEM_W = 32;
  localparam int IN_TDATA_W = 40;
  localparam int OUT_TDATA_W = 56;
  localparam logic [CNT_W-1:0] QLEN_RESET = 7'd64;
  localparam logic [CNT_W-1:0] RUN_OFF_MAX = 7'd127;

  typedef enum logic [2:0] {
    MODE_PUSH       = 3'd0,
    MODE_POP        = 3'd1,
    MODE_PEEK       = 3'd2,
    MODE_PUSH_BATCH = 3'd3,
    MODE_POP_BATCH  = 3'd4,
    MODE_PEEK_BATCH = 3'd5,
    MODE_RESET      = 3'd6,
    MODE_OVERWRITE  = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // slave-side tdata, lowest field at the bottom
  typedef struct packed {
    logic [0:0]        pad;
    logic [CNT_W-1:0]  count;
    logic [ELEM_W-1:0] element;
  } in_word_t;

  // master-side tdata, lowest field at the bottom
  typedef struct packed {
    logic [3:0]        pad;
    logic              index_valid;
    logic [PTR_W-1:0]  newest_index;
    logic [PTR_W-1:0]  first_index;
    logic [CNT_W-1:0]  occupancy;
    logic [ELEM_W-1:0] data_out;
  } out_word_t;

  // outcome of one operation, handed from the controller to the read sequencer
  typedef struct packed {
    status_t          status;
    logic [CNT_W-1:0] occupancy;
    logic [PTR_W-1:0] first_index;
    logic [PTR_W-1:0] newest_index;
    logic             index_valid;
    logic [CNT_W-1:0] nreads;
    logic [PTR_W-1:0] rd_base;
  } op_res_t;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p,
                                                input logic [CNT_W-1:0] len);
    logic [CNT_W-1:0] s;
    s = {1'b0, p} + 7'd1;
    return (s == len) ? '0 : s[PTR_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] occ_of(input logic [PTR_W-1:0] rp,
                                              input logic [PTR_W-1:0] wp,
                                              input logic             full,
                                              input logic [CNT_W-1:0] len);
    logic [CNT_W-1:0] d;
    d = {1'b0, wp} - {1'b0, rp};
    if (full) return len;
    if (wp >= rp) return d;
    return len + d;
  endfunction

endpackage

FILE: rtl/ring_fifo_with_batch_ops.sv
// ----------------------------------------------------------------------------
// ring_fifo_with_batch_ops
// Circular FIFO with single, batch, reset and overwrite operations.
//
// Slave stream carries one operation per transfer: tuser is the mode, tdata
// holds element and count, tlast closes a push-batch run. The master stream
// returns results: tuser is the status, tlast marks the last result of an
// operation, tdata holds read data, occupancy and the oldest/newest slots.
// cfg_* writes the queue length and empties the queue.
// Operations without a read give one result, registered in the cycle after
// the transfer; the next operation is taken in the cycle that result leaves.
// Pop, peek and the batch reads go through the slot RAM, one read per cycle
// unless a stalled output holds them; each read passes the RAM read register
// into the output register, and results stream one per cycle while m_tready
// holds. A new operation waits until the last read has reached the output
// register, so RAM reads never see a pending write. A stalled receiver holds
// the output register and the read pipeline; tready drops until it drains.
// Reset empties the queue and sets the length to 64; the RAM is not cleared.
// ----------------------------------------------------------------------------
module ring_fifo_with_batch_ops import rfb_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // element[31:0], count[38:32]
  input  logic [2:0]             s_tuser,   // mode[2:0]
  input  logic                   s_tlast,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // data_out[31:0], occupancy[38:32],
                                            // first_index[44:39],
                                            // newest_index[50:45], index_valid[51]
  output logic [1:0]             m_tuser,   // status[1:0]
  output logic                   m_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CNT_W-1:0]       cfg_data
);

  localparam int SW = (WIDTH < ELEM_W) ? WIDTH : ELEM_W;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  in_word_t          in_w;
  op_res_t           res;
  op_res_t           meta;
  logic [CNT_W-1:0]  len;
  logic              accept;
  logic              mem_we;
  logic [PTR_W-1:0]  mem_waddr;
  logic [ELEM_W-1:0] mem_wdata;
  logic              rd_en;
  logic [PTR_W-1:0]  rd_addr;
  logic [SW-1:0]     rdata;
  logic [CNT_W-1:0]  rd_left, rd_left_next;
  logic [PTR_W-1:0]  rd_ptr, rd_ptr_next;
  logic              pend, pend_last;
  logic              out_free;
  logic              load_rd, load_st;
  out_word_t         out_q;
  status_t           out_st;
  logic              out_last;

  assign in_w      = in_word_t'(s_tdata);
  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (rd_left == '0) && !pend && out_free;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  rfb_queue_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid),
    .cfg_len  (cfg_data),
    .op_valid (accept),
    .mode     (mode_t'(s_tuser)),
    .element  (in_w.element),
    .count    (in_w.count),
    .run_last (s_tlast),
    .res      (res),
    .len      (len),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata)
  );

  // first read goes out in the transfer cycle, the rest follow one per cycle unless a stalled output holds them
  always_comb begin
    rd_left_next = rd_left;
    rd_ptr_next  = rd_ptr;
    rd_en        = 1'b0;
    rd_addr      = rd_ptr;
    if (accept && res.nreads != '0) begin
      rd_en        = 1'b1;
      rd_addr      = res.rd_base;
      rd_left_next = res.nreads - 7'd1;
      rd_ptr_next  = wrap_inc(res.rd_base, len);
    end else if (rd_left != '0 && (!pend || out_free)) begin
      rd_en        = 1'b1;
      rd_left_next = rd_left - 7'd1;
      rd_ptr_next  = wrap_inc(rd_ptr, len);
    end
  end

  // only an accepted transfer may write; a waiting one must not touch slots
  rfb_slot_ram #(.DEPTH(DEPTH), .SW(SW), .AW(AW)) u_ram (
    .clk  (clk),
    .we   (mem_we && accept),
    .waddr(mem_waddr[AW-1:0]),
    .wdata(mem_wdata[SW-1:0]),
    .re   (rd_en),
    .raddr(rd_addr[AW-1:0]),
    .rdata(rdata)
  );

  assign load_rd = pend && out_free;
  assign load_st = accept && res.nreads == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_left   <= '0;
      rd_ptr    <= '0;
      pend      <= 1'b0;
      pend_last <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      rd_left <= rd_left_next;
      rd_ptr  <= rd_ptr_next;
      if (rd_en) begin
        pend      <= 1'b1;
        pend_last <= (rd_left_next == '0);
      end else if (load_rd) begin
        pend <= 1'b0;
      end
      if (load_rd || load_st) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      meta <= res;
    end
    if (load_rd) begin
      out_q.pad          <= '0;
      out_q.index_valid  <= meta.index_valid;
      out_q.newest_index <= meta.newest_index;
      out_q.first_index  <= meta.first_index;
      out_q.occupancy    <= meta.occupancy;
      out_q.data_out     <= ELEM_W'(rdata);
      out_st             <= meta.status;
      out_last           <= pend_last;
    end else if (load_st) begin
      out_q.pad          <= '0;
      out_q.index_valid  <= res.index_valid;
      out_q.newest_index <= res.newest_index;
      out_q.first_index  <= res.first_index;
      out_q.occupancy    <= res.occupancy;
      out_q.data_out     <= '0;
      out_st             <= res.status;
      out_last           <= 1'b1;
    end
  end

  assign m_tdata = out_q;
  assign m_tuser = out_st;
  assign m_tlast = out_last;

  a_read_lands: assert property (@(posedge clk) disable iff (rst)
    (accept && res.nreads != '0) |=> pend)
    else $error("read issued on transfer left no pending data");

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_q.occupancy <= len))
    else $error("reported occupancy exceeds queue length");

  a_idx_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_q.index_valid == (out_q.occupancy != '0)))
    else $error("index_valid disagrees with occupancy");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (rd_left != '0) |-> !accept)
    else $error("operation taken while batch reads remain");

endmodule

FILE: rtl/rfb_slot_ram.sv
// ----------------------------------------------------------------------------
// rfb_slot_ram
// Element store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rfb_slot_ram #(
  parameter int DEPTH = 64,
  parameter int SW    = 32,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [SW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [SW-1:0] rdata
);

  logic [SW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/rfb_queue_ctrl.sv
// ----------------------------------------------------------------------------
// rfb_queue_ctrl
// Pointer, full mark and push-run state; decodes one operation per transfer.
// ----------------------------------------------------------------------------
module rfb_queue_ctrl import rfb_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CNT_W-1:0]  cfg_len,
  input  logic              op_valid,
  input  mode_t             mode,
  input  logic [ELEM_W-1:0] element,
  input  logic [CNT_W-1:0]  count,
  input  logic              run_last,
  output op_res_t           res,
  output logic [CNT_W-1:0]  len,
  output logic              mem_we,
  output logic [PTR_W-1:0]  mem_waddr,
  output logic [ELEM_W-1:0] mem_wdata
);

  localparam logic [CNT_W-1:0] LEN_MAX = CNT_W'(DEPTH);

  logic [PTR_W-1:0] rp, rp_next;
  logic [PTR_W-1:0] wp, wp_next;
  logic             full, full_next;
  logic             run_open, run_open_next;
  logic             run_acc, run_acc_next;
  logic [CNT_W-1:0] run_off, run_off_next;
  logic [CNT_W-1:0] qlen;
  logic [CNT_W-1:0] occ, occ_next;
  logic [CNT_W-1:0] rp_sum;
  logic             acc_e;
  logic [CNT_W-1:0] off_e;

  always_comb begin
    if (qlen == '0) len = 7'd1;
    else if (qlen > LEN_MAX) len = LEN_MAX;
    else len = qlen;
  end

  assign occ    = occ_of(rp, wp, full, len);
  assign rp_sum = {1'b0, rp} + count;

  always_comb begin
    rp_next       = rp;
    wp_next       = wp;
    full_next     = full;
    run_open_next = (mode == MODE_PUSH_BATCH) ? run_open : 1'b0;
    run_acc_next  = run_acc;
    run_off_next  = run_off;
    acc_e         = run_acc;
    off_e         = run_off;
    mem_we        = 1'b0;
    mem_waddr     = wp;
    mem_wdata     = element;
    res.status    = ST_OK;
    res.nreads    = '0;
    res.rd_base   = rp;
    unique case (mode)
      MODE_PUSH: begin
        if (full) begin
          res.status = ST_FULL;
        end else begin
          mem_we    = 1'b1;
          wp_next   = wrap_inc(wp, len);
          full_next = (wrap_inc(wp, len) == rp);
        end
      end
      MODE_POP, MODE_PEEK: begin
        if (occ == '0) begin
          res.status = ST_EMPTY;
        end else begin
          res.nreads = 7'd1;
          if (mode == MODE_POP) begin
            rp_next   = wrap_inc(rp, len);
            full_next = 1'b0;
          end
        end
      end
      MODE_PUSH_BATCH: begin
        // a zero-count item outside a run is a no-op
        if (run_open || count != '0) begin
          if (!run_open) begin
            acc_e = (len - occ) >= count;
            off_e = '0;
          end
          run_acc_next = acc_e;
          if (acc_e && off_e < count && !full) begin
            mem_we    = 1'b1;
            wp_next   = wrap_inc(wp, len);
            full_next = (wrap_inc(wp, len) == rp);
          end else begin
            res.status = ST_FULL;
          end
          run_off_next  = (off_e < RUN_OFF_MAX) ? off_e + 7'd1 : off_e;
          run_open_next = !run_last;
        end
      end
      MODE_POP_BATCH, MODE_PEEK_BATCH: begin
        if (occ < count) begin
          res.status = ST_EMPTY;
        end else if (count != '0) begin
          res.nreads = count;
          if (mode == MODE_POP_BATCH) begin
            rp_next   = (rp_sum >= len) ? PTR_W'(rp_sum - len) : rp_sum[PTR_W-1:0];
            full_next = 1'b0;
          end
        end
      end
      MODE_RESET: begin
        rp_next   = '0;
        wp_next   = '0;
        full_next = 1'b0;
      end
      MODE_OVERWRITE: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        rp_next   = '0;
        wp_next   = wrap_inc('0, len);
        full_next = (len == 7'd1);
      end
      default: begin
        res.status = ST_OK;
      end
    endcase
    occ_next         = occ_of(rp_next, wp_next, full_next, len);
    res.occupancy    = occ_next;
    res.index_valid  = (occ_next != '0);
    res.first_index  = res.index_valid ? rp_next : '0;
    res.newest_index = !res.index_valid ? '0 :
                       (wp_next == '0) ? PTR_W'(len - 7'd1) : wp_next - 6'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rp       <= '0;
      wp       <= '0;
      full     <= 1'b0;
      run_open <= 1'b0;
      run_acc  <= 1'b0;
      run_off  <= '0;
      qlen     <= QLEN_RESET;
    end else if (cfg_we) begin
      qlen     <= cfg_len;
      rp       <= '0;
      wp       <= '0;
      full     <= 1'b0;
      run_open <= 1'b0;
    end else if (op_valid) begin
      rp       <= rp_next;
      wp       <= wp_next;
      full     <= full_next;
      run_open <= run_open_next;
      run_acc  <= run_acc_next;
      run_off  <= run_off_next;
    end
  end

endmodule

FILE: sim/tb_ring_fifo_with_batch_ops.sv
// ----------------------------------------------------------------------------
// tb_ring_fifo_with_batch_ops
// Self-checking bench for the ring FIFO with batch operations. A behavioral
// copy of the queue predicts every result of each accepted operation. Results
// are compared field by field in order. Directed cases cover empty/full
// corners, short and clamped lengths and push-batch run handling. Random
// traffic then runs under several queue lengths and stall patterns.
// ----------------------------------------------------------------------------
module tb_ring_fifo_with_batch_ops;
  import rfb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;   // element[31:0], count[38:32]
  logic [2:0]             s_tuser = '0;   // mode[2:0]
  logic                   s_tlast = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;        // data_out[31:0], occupancy[38:32],
                                          // first_index[44:39],
                                          // newest_index[50:45], index_valid[51]
  logic [1:0]             m_tuser;        // status[1:0]
  logic                   m_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CNT_W-1:0]       cfg_data = '0;

  typedef struct {
    status_t          status;
    logic [31:0]      data;
    logic             fin;
    logic [CNT_W-1:0] occ;
    logic [PTR_W-1:0] first;
    logic [PTR_W-1:0] newest;
    logic             iv;
  } fifo_result_t;

  fifo_result_t pending_results[$];
  int err_cnt = 0;
  int snd_idle_pct = 9;
  int rcv_idle_pct = 50;

  // queue image
  logic [31:0]      slot_mem [DEPTH];
  int unsigned      rd_p = 0;
  int unsigned      wr_p = 0;
  int unsigned      run_off = 0;
  bit               full_m = 1'b0;
  bit               run_open = 1'b0;
  bit               run_ok = 1'b0;
  logic [CNT_W-1:0] qlen_reg = QLEN_RESET;

  ring_fifo_with_batch_ops uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  function automatic int unsigned len_eff();
    if (qlen_reg == 0) return 1;
    if (qlen_reg > DEPTH) return DEPTH;
    return int'(qlen_reg);
  endfunction

  function automatic int unsigned fill_level();
    if (full_m) return len_eff();
    if (wr_p >= rd_p) return wr_p - rd_p;
    return len_eff() + wr_p - rd_p;
  endfunction

  function automatic void store_elem(logic [31:0] v);
    slot_mem[wr_p] = v;
    wr_p = (wr_p + 1) % len_eff();
    if (wr_p == rd_p) full_m = 1'b1;
  endfunction

  function automatic void clear_queue();
    rd_p = 0;
    wr_p = 0;
    full_m = 1'b0;
  endfunction

  // expected result stream of one operation
  function automatic void predict_fifo_op(mode_t m, logic [31:0] e, logic [CNT_W-1:0] c,
                                          logic l);
    logic [31:0]  rd_data [DEPTH];
    status_t      st;
    int unsigned  n;
    int unsigned  len;
    int unsigned  occ;
    fifo_result_t r;
    st = ST_OK;
    n = 1;
    len = len_eff();
    occ = fill_level();
    rd_data[0] = '0;
    if (m != MODE_PUSH_BATCH) run_open = 1'b0;
    case (m)
      MODE_PUSH: begin
        if (full_m) st = ST_FULL;
        else store_elem(e);
      end
      MODE_POP, MODE_PEEK: begin
        if (occ == 0) begin
          st = ST_EMPTY;
        end else begin
          rd_data[0] = slot_mem[rd_p];
          if (m == MODE_POP) begin
            rd_p = (rd_p + 1) % len;
            full_m = 1'b0;
          end
        end
      end
      MODE_PUSH_BATCH: begin
        // zero count with no open run is a no-op
        if (run_open || c != 0) begin
          if (!run_open) begin
            run_open = 1'b1;
            run_off = 0;
            run_ok = (len - occ) >= c;
          end
          if (run_ok && run_off < c && !full_m) store_elem(e);
          else st = ST_FULL;
          if (run_off < RUN_OFF_MAX) run_off++;
          if (l) run_open = 1'b0;
        end
      end
      MODE_POP_BATCH, MODE_PEEK_BATCH: begin
        if (occ < c) begin
          st = ST_EMPTY;
        end else if (c > 0) begin
          n = int'(c);
          for (int k = 0; k < c; k++) rd_data[k] = slot_mem[(rd_p + k) % len];
          if (m == MODE_POP_BATCH) begin
            rd_p = (rd_p + c) % len;
            full_m = 1'b0;
          end
        end
      end
      MODE_RESET: clear_queue();
      default: begin
        clear_queue();
        store_elem(e);
      end
    endcase
    occ = fill_level();
    for (int k = 0; k < n; k++) begin
      r.status = st;
      r.data = rd_data[k];
      r.fin = (k + 1 == n);
      r.occ = CNT_W'(occ);
      r.first = (occ != 0) ? PTR_W'(rd_p) : '0;
      r.newest = (occ != 0) ? PTR_W'((wr_p + len - 1) % len) : '0;
      r.iv = (occ != 0);
      pending_results.push_back(r);
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_cnt++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    fifo_result_t want;
    out_word_t    ow;
    if (!rst && m_tvalid && m_tready) begin
      ow = m_tdata;
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected");
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(m_tuser));
        check_field("data_out", want.data, ow.data_out);
        check_field("final_flag", 32'(want.fin), 32'(m_tlast));
        check_field("occupancy", 32'(want.occ), 32'(ow.occupancy));
        check_field("first_index", 32'(want.first), 32'(ow.first_index));
        check_field("newest_index", 32'(want.newest), 32'(ow.newest_index));
        check_field("index_valid", 32'(want.iv), 32'(ow.index_valid));
      end
    end
  end

  task automatic send_op(mode_t m, logic [31:0] e, logic [CNT_W-1:0] c, logic l);
    int gap;
    if ($urandom_range(99) < snd_idle_pct) begin
      gap = $urandom_range(3, 1);
      repeat (gap) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
      end
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, c, e};
    s_tuser <= m;
    s_tlast <= l;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_fifo_op(m, e, c, l);
  endtask

  // stop sending and wait for every expected result, plus pipeline slack
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_qlen(logic [CNT_W-1:0] v);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    qlen_reg = v;
    clear_queue();
    run_open = 1'b0;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_single_ops();
    send_op(MODE_POP, 32'h0, 7'd0, 1'b0);
    send_op(MODE_PEEK_BATCH, 32'h0, 7'd0, 1'b0);
    send_op(MODE_PUSH, 32'hFFFF_FFFF, 7'd127, 1'b1);
    send_op(MODE_PUSH, 32'h0, 7'd0, 1'b0);
    send_op(MODE_PEEK, 32'h0, 7'd0, 1'b0);
    send_op(MODE_POP_BATCH, 32'h0, 7'd3, 1'b0);
    send_op(MODE_PUSH_BATCH, 32'h1234_5678, 7'd0, 1'b1);
    send_op(MODE_PUSH_BATCH, 32'h8765_4321, 7'd64, 1'b1);
    send_op(MODE_PUSH_BATCH, 32'hDEAD_BEEF, 7'd2, 1'b0);
    send_op(MODE_PUSH_BATCH, 32'hCAFE_F00D, 7'd2, 1'b1);
    send_op(MODE_PEEK_BATCH, 32'h0, 7'd4, 1'b0);
    send_op(MODE_POP_BATCH, 32'h0, 7'd4, 1'b0);
    send_op(MODE_OVERWRITE, 32'h5A5A_5A5A, 7'd0, 1'b0);
    send_op(MODE_RESET, 32'h0, 7'd0, 1'b0);
    send_op(MODE_PEEK, 32'h0, 7'd0, 1'b0);
  endtask

  task automatic test_short_queue();
    write_qlen(7'd1);
    send_op(MODE_PUSH, 32'h0000_0011, 7'd0, 1'b0);
    send_op(MODE_PUSH, 32'h0000_0022, 7'd0, 1'b0);
    send_op(MODE_OVERWRITE, 32'h0000_0033, 7'd0, 1'b0);
    send_op(MODE_POP, 32'h0, 7'd0, 1'b0);
    // zero length behaves as one slot; second item of the run is excess
    write_qlen(7'd0);
    send_op(MODE_PUSH_BATCH, 32'h0000_0044, 7'd1, 1'b0);
    send_op(MODE_PUSH_BATCH, 32'h0000_0055, 7'd1, 1'b1);
  endtask

  task automatic test_run_close();
    write_qlen(7'd4);
    send_op(MODE_PUSH_BATCH, 32'h0000_0101, 7'd3, 1'b0);
    send_op(MODE_PUSH_BATCH, 32'h0000_0102, 7'd3, 1'b0);
    send_op(MODE_POP, 32'h0, 7'd0, 1'b0);
    send_op(MODE_PUSH_BATCH, 32'h0000_0103, 7'd3, 1'b0);
    // length write closes the open run; 127 clamps to 64 slots
    write_qlen(7'd127);
    send_op(MODE_PUSH_BATCH, 32'h0000_0104, 7'd1, 1'b1);
  endtask

  task automatic run_random(int n_items);
    int          done;
    int          pick;
    int          shape;
    bit          with_last;
    int unsigned len;
    int unsigned occ;
    int unsigned free;
    int unsigned c;
    int unsigned n_run;
    done = 0;
    while (done < n_items) begin
      len = len_eff();
      occ = fill_level();
      free = len - occ;
      pick = $urandom_range(99);
      if (pick < 28) begin
        send_op(MODE_PUSH, $urandom, CNT_W'($urandom_range(64, 0)), 1'($urandom_range(1)));
        done++;
      end else if (pick < 42) begin
        send_op(MODE_POP, $urandom, CNT_W'($urandom_range(64, 0)), 1'($urandom_range(1)));
        done++;
      end else if (pick < 48) begin
        send_op(MODE_PEEK, $urandom, CNT_W'($urandom_range(64, 0)), 1'($urandom_range(1)));
        done++;
      end else if (pick < 68) begin
        if (free == 0 || $urandom_range(4) == 0) c = $urandom_range(len, 1);
        else c = $urandom_range((free < 8) ? free : 8, 1);
        shape = $urandom_range(9);
        with_last = 1'b1;
        n_run = c;
        if (shape == 0) begin
          n_run = $urandom_range(c, 1);   // cut short, left open for whatever follows
          with_last = 1'b0;
        end else if (shape == 1) begin
          n_run = c + $urandom_range(3, 1);
        end else if (shape == 2) begin
          with_last = 1'b0;
        end
        for (int i = 0; i < n_run; i++)
          send_op(MODE_PUSH_BATCH, $urandom, CNT_W'(c), with_last && (i == n_run - 1));
        done += n_run;
      end else if (pick < 88) begin
        if ($urandom_range(4) == 0) c = $urandom_range(64, 0);
        else c = $urandom_range(occ, 0);
        if (pick < 80) send_op(MODE_POP_BATCH, $urandom, CNT_W'(c), 1'($urandom_range(1)));
        else send_op(MODE_PEEK_BATCH, $urandom, CNT_W'(c), 1'($urandom_range(1)));
        done++;
      end else if (pick < 91) begin
        send_op(MODE_RESET, $urandom, CNT_W'($urandom_range(64, 0)), 1'($urandom_range(1)));
        done++;
      end else if (pick < 95) begin
        send_op(MODE_OVERWRITE, $urandom, CNT_W'($urandom_range(64, 0)),
                1'($urandom_range(1)));
        done++;
      end else if (pick < 97) begin
        // ignored unless a run is open
        send_op(MODE_PUSH_BATCH, $urandom, 7'd0, 1'($urandom_range(1)));
        done++;
      end else begin
        send_op(MODE_PUSH_BATCH, $urandom, CNT_W'($urandom_range(64, 0)),
                1'($urandom_range(1)));
        done++;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_single_ops();
    test_short_queue();
    test_run_close();

    write_qlen(7'd8);
    run_random(55);
    write_qlen(7'd64);
    run_random(55);

    snd_idle_pct = 50;
    rcv_idle_pct = 9;
    write_qlen(7'd3);
    run_random(55);
    write_qlen(CNT_W'($urandom_range(64, 1)));
    run_random(55);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    write_qlen(7'd2);
    run_random(60);
    write_qlen(7'd64);
    run_random(60);

    drain();
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
